>>> design/dcs_pkg.sv
// shared constants, types and helpers for the downmix cosine similarity block
`default_nettype none
package dcs_pkg;

  localparam int unsigned FIELD_BITS = 24;
  localparam int unsigned FIELD_CH   = 4;
  localparam int unsigned CFG_BITS   = 3;
  localparam int unsigned ACC_BITS   = 64;
  localparam int unsigned SCORE_BITS = 18;
  localparam int unsigned Q_BITS     = 17;
  localparam int unsigned BIG_W      = 162;
  localparam int unsigned BM_STEPS   = 8;

  localparam int unsigned DEF_MAX_CHANNELS = 4;
  localparam int unsigned DEF_SAMPLE_BITS  = 24;

  localparam logic CFG_MIC_CHANNELS = 1'b0;
  localparam logic CFG_FAR_CHANNELS = 1'b1;

  typedef struct packed {
    logic load;
    logic mul;
    logic acc;
    logic bm;
    logic srch_a;
    logic srch_b;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic zero;
    logic bm_done;
    logic srch_last;
    logic out_busy;
  } sts_t;

  // rounded Q1.16 reciprocal of a channel count of 1 to 7
  function automatic logic [Q_BITS-1:0] recip(input logic [CFG_BITS-1:0] n);
    logic [Q_BITS-1:0] r;
    unique case (n)
      3'd1:    r = 17'd65536;
      3'd2:    r = 17'd32768;
      3'd3:    r = 17'd21845;
      3'd4:    r = 17'd16384;
      3'd5:    r = 17'd13107;
      3'd6:    r = 17'd10923;
      3'd7:    r = 17'd9362;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/dcs_ctrl.sv
// sequencing state machine of the downmix cosine similarity block
`default_nettype none
module dcs_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  dcs_pkg::sts_t      sts_i,
  output dcs_pkg::cmd_t      cmd_o
);
  import dcs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_ACC, ST_BM, ST_SA, ST_SB, ST_FIN
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: if (in_valid_i) state_q <= ST_MUL;
        ST_MUL:  state_q <= ST_ACC;
        ST_ACC: begin
          if (!sts_i.last) state_q <= ST_IDLE;
          else             state_q <= ST_BM;
        end
        // energy check sees the sums after the last frame was added
        ST_BM: begin
          priority if (sts_i.zero) state_q <= ST_FIN;
          else if (sts_i.bm_done)  state_q <= ST_SA;
        end
        ST_SA:   state_q <= ST_SB;
        ST_SB:   state_q <= sts_i.srch_last ? ST_FIN : ST_SA;
        ST_FIN:  if (!sts_i.out_busy) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.mul    = (state_q == ST_MUL);
    cmd_o.acc    = (state_q == ST_ACC);
    cmd_o.bm     = (state_q == ST_BM);
    cmd_o.srch_a = (state_q == ST_SA);
    cmd_o.srch_b = (state_q == ST_SB);
    cmd_o.finish = (state_q == ST_FIN) && !sts_i.out_busy;
  end

endmodule
`default_nettype wire

>>> design/dcs_datapath.sv
// downmix, accumulators, shared wide multiplier and score search
`default_nettype none
module dcs_datapath #(
  parameter int unsigned MAX_CHANNELS = dcs_pkg::DEF_MAX_CHANNELS,
  parameter int unsigned SAMPLE_BITS  = dcs_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic                                  cfg_idx_i,
  input  wire logic [dcs_pkg::CFG_BITS-1:0]          cfg_data_i,
  input  wire logic signed [dcs_pkg::FIELD_BITS-1:0] mic_s_i [dcs_pkg::FIELD_CH],
  input  wire logic signed [dcs_pkg::FIELD_BITS-1:0] far_s_i [dcs_pkg::FIELD_CH],
  input  wire logic                                  frame_present_i,
  input  wire logic                                  last_frame_i,
  input  wire logic                                  out_ready_i,
  output logic                                       out_valid_o,
  output logic signed [dcs_pkg::SCORE_BITS-1:0]      score_o,
  input  dcs_pkg::cmd_t                              cmd_i,
  output dcs_pkg::sts_t                              sts_o
);
  import dcs_pkg::*;

  localparam int unsigned LIM = (MAX_CHANNELS < FIELD_CH) ? MAX_CHANNELS : FIELD_CH;
  localparam int unsigned SH  = FIELD_BITS - SAMPLE_BITS;
  localparam int unsigned SUM_W  = FIELD_BITS + 2;
  localparam int unsigned PROD_W = SUM_W + Q_BITS + 1;
  localparam logic signed [PROD_W-1:0] MAXV = (PROD_W'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam logic signed [PROD_W-1:0] MINV = -MAXV - 1;
  localparam int unsigned MP_W = 2 * FIELD_BITS;

  logic [CFG_BITS-1:0] mic_ch_q, far_ch_q;

  logic signed [FIELD_BITS-1:0] m_q, f_q;
  logic present_q, last_q;
  logic signed [MP_W-1:0] mf_q, mm_q, ff_q;

  logic signed [ACC_BITS-1:0] dot_q;
  logic [ACC_BITS-1:0] mic_e_q, far_e_q;
  logic seen_q;

  logic [3:0] bm_cnt_q;
  logic [2:0] pk_q;
  logic [ACC_BITS-1:0] pp_q, mag_q;
  logic [2*ACC_BITS-1:0] p_q, d_q;

  logic [BIG_W-1:0] x_q, yb_q, ps_q, tmp_q;
  logic [4:0] bit_q;
  logic [Q_BITS-1:0] q_q;

  logic out_valid_q;
  logic signed [SCORE_BITS-1:0] score_q;

  function automatic logic [CFG_BITS-1:0] eff_ch(input logic [CFG_BITS-1:0] reg_v);
    logic [CFG_BITS-1:0] n;
    n = (reg_v == '0) ? CFG_BITS'(1) : reg_v;
    if (n > CFG_BITS'(LIM)) n = CFG_BITS'(LIM);
    return n;
  endfunction

  function automatic logic signed [FIELD_BITS-1:0] mono(
    input logic signed [FIELD_BITS-1:0] s [FIELD_CH],
    input logic [CFG_BITS-1:0]          reg_v
  );
    logic [CFG_BITS-1:0] n;
    logic signed [SUM_W-1:0] sum;
    logic signed [FIELD_BITS-1:0] v;
    logic signed [PROD_W-1:0] p;
    n   = eff_ch(reg_v);
    sum = '0;
    for (int i = 0; i < FIELD_CH; i++) begin
      v = $signed(s[i] << SH) >>> SH;
      if (CFG_BITS'(i) < n) sum = sum + SUM_W'(v);
    end
    p = PROD_W'(sum) * $signed({1'b0, recip(n)});
    p = (p + PROD_W'(32768)) >>> 16;
    if (p > MAXV) p = MAXV;
    if (p < MINV) p = MINV;
    return p[FIELD_BITS-1:0];
  endfunction

  // saturating accumulation
  logic signed [ACC_BITS:0] dot_sum;
  logic [ACC_BITS:0] mic_sum, far_sum;
  assign dot_sum = {dot_q[ACC_BITS-1], dot_q} + (ACC_BITS+1)'(mf_q);
  assign mic_sum = {1'b0, mic_e_q} + (ACC_BITS+1)'($unsigned(mm_q));
  assign far_sum = {1'b0, far_e_q} + (ACC_BITS+1)'($unsigned(ff_q));

  // shared 32x32 multiplier operands
  logic [31:0] ah, bh;
  always_comb begin
    if (bm_cnt_q[2]) begin
      ah = bm_cnt_q[0] ? mag_q[63:32] : mag_q[31:0];
      bh = bm_cnt_q[1] ? mag_q[63:32] : mag_q[31:0];
    end else begin
      ah = bm_cnt_q[0] ? mic_e_q[63:32] : mic_e_q[31:0];
      bh = bm_cnt_q[1] ? far_e_q[63:32] : far_e_q[31:0];
    end
  end

  logic [2*ACC_BITS-1:0] pp_sh;
  assign pp_sh = {64'd0, pp_q} << (32 * (32'(pk_q[0]) + 32'(pk_q[1])));

  logic [BIG_W-1:0] d_big, t_big;
  logic srch_ok;
  assign d_big   = BIG_W'({d_q, 32'd0});
  assign t_big   = x_q + tmp_q;
  assign srch_ok = (t_big <= d_big);

  logic [ACC_BITS-1:0] mag_now;
  assign mag_now = dot_q[ACC_BITS-1] ? (ACC_BITS'(0) - $unsigned(dot_q)) : $unsigned(dot_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mic_ch_q    <= CFG_BITS'(1);
      far_ch_q    <= CFG_BITS'(1);
      dot_q       <= '0;
      mic_e_q     <= '0;
      far_e_q     <= '0;
      seen_q      <= 1'b0;
      bm_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MIC_CHANNELS: mic_ch_q <= cfg_data_i;
          CFG_FAR_CHANNELS: far_ch_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.acc) begin
        bm_cnt_q <= '0;
        if (present_q) begin
          priority if (dot_sum[ACC_BITS] != dot_sum[ACC_BITS-1])
            dot_q <= dot_sum[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                       : {1'b0, {(ACC_BITS-1){1'b1}}};
          else
            dot_q <= dot_sum[ACC_BITS-1:0];
          mic_e_q <= mic_sum[ACC_BITS] ? '1 : mic_sum[ACC_BITS-1:0];
          far_e_q <= far_sum[ACC_BITS] ? '1 : far_sum[ACC_BITS-1:0];
          seen_q  <= 1'b1;
        end
      end
      if (cmd_i.bm) bm_cnt_q <= bm_cnt_q + 4'd1;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        dot_q       <= '0;
        mic_e_q     <= '0;
        far_e_q     <= '0;
        seen_q      <= 1'b0;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m_q       <= mono(mic_s_i, mic_ch_q);
      f_q       <= mono(far_s_i, far_ch_q);
      present_q <= frame_present_i;
      last_q    <= last_frame_i;
    end
    if (cmd_i.mul) begin
      mf_q <= m_q * f_q;
      mm_q <= m_q * m_q;
      ff_q <= f_q * f_q;
    end
    if (cmd_i.bm) begin
      pp_q <= ah * bh;
      pk_q <= bm_cnt_q[2:0];
      if (bm_cnt_q == 4'd0) begin
        mag_q <= mag_now;
        p_q   <= '0;
        d_q   <= '0;
      end else if (pk_q[2]) begin
        d_q <= d_q + pp_sh;
      end else begin
        p_q <= p_q + pp_sh;
      end
      if (bm_cnt_q == 4'(BM_STEPS)) begin
        x_q   <= '0;
        yb_q  <= '0;
        ps_q  <= BIG_W'({p_q, 32'd0});
        bit_q <= 5'(Q_BITS - 1);
        q_q   <= '0;
      end
    end
    if (cmd_i.srch_a) tmp_q <= yb_q + ps_q;
    if (cmd_i.srch_b) begin
      if (srch_ok) begin
        x_q          <= t_big;
        q_q[bit_q]   <= 1'b1;
        yb_q         <= (tmp_q + ps_q) >> 1;
      end else begin
        yb_q <= yb_q >> 1;
      end
      ps_q  <= ps_q >> 2;
      bit_q <= bit_q - 5'd1;
    end
    if (cmd_i.finish) begin
      priority if (sts_o.zero)     score_q <= '0;
      else if (dot_q[ACC_BITS-1])  score_q <= -$signed({1'b0, q_q});
      else                         score_q <= $signed({1'b0, q_q});
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.last      = last_q;
    sts_o.zero      = !seen_q || (mic_e_q == '0) || (far_e_q == '0);
    sts_o.bm_done   = (bm_cnt_q == 4'(BM_STEPS));
    sts_o.srch_last = (bit_q == 5'd0) || ((bit_q == 5'(Q_BITS - 1)) && srch_ok);
    sts_o.out_busy  = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign score_o     = score_q;

endmodule
`default_nettype wire

>>> design/downmix_cosine_similarity.sv
// Downmix cosine similarity: zero-lag normalized correlation of mic and remote audio.
// Input channel: in_valid_i/in_ready_o carry one frame of four mic and four remote
// samples plus frame_present_i and last_frame_i. Each side is averaged to mono over
// its configured channel count; present frames feed a dot product and two energies.
// A frame with last_frame_i set produces one transaction on the output channel
// (out_valid_o/out_ready_i) carrying score_o in Q1.16, then all sums are cleared.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 mic channel count, 1 remote channel count); the user must write only while
// idle, as the block itself does not enforce it. A frame that is not last passes
// through downmix, multiply and accumulate, and the single-item sequencer takes no
// new frame before it is done. A last frame with energy then uses the shared 32x32
// multiplier to form the 128-bit energy product and squared dot, then runs a
// bit-serial square-root/divide search over 17 score bits (states ST_SA and ST_SB
// for each bit, ending early when the score is exactly one), then loads the output
// register. A last frame with no energy takes an energy check, then loads it.
// If the receiver stalls with a score still held, the next score waits in the
// sequencer and no new frame is taken until the output register frees.
// Reset clears the sums, sets both channel counts to 1 and empties the output.
`default_nettype none
module downmix_cosine_similarity #(
  parameter int unsigned MAX_CHANNELS = dcs_pkg::DEF_MAX_CHANNELS,
  parameter int unsigned SAMPLE_BITS  = dcs_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic                                  cfg_idx_i,
  input  wire logic [dcs_pkg::CFG_BITS-1:0]          cfg_data_i,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic signed [dcs_pkg::FIELD_BITS-1:0] mic_s0_i,
  input  wire logic signed [dcs_pkg::FIELD_BITS-1:0] mic_s1_i,
  input  wire logic signed [dcs_pkg::FIELD_BITS-1:0] mic_s2_i,
  input  wire logic signed [dcs_pkg::FIELD_BITS-1:0] mic_s3_i,
  input  wire logic signed [dcs_pkg::FIELD_BITS-1:0] far_s0_i,
  input  wire logic signed [dcs_pkg::FIELD_BITS-1:0] far_s1_i,
  input  wire logic signed [dcs_pkg::FIELD_BITS-1:0] far_s2_i,
  input  wire logic signed [dcs_pkg::FIELD_BITS-1:0] far_s3_i,
  input  wire logic                                  frame_present_i,
  input  wire logic                                  last_frame_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic signed [dcs_pkg::SCORE_BITS-1:0]      score_o
);
  import dcs_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic signed [FIELD_BITS-1:0] mic_s [FIELD_CH];
  logic signed [FIELD_BITS-1:0] far_s [FIELD_CH];

  assign mic_s[0] = mic_s0_i;
  assign mic_s[1] = mic_s1_i;
  assign mic_s[2] = mic_s2_i;
  assign mic_s[3] = mic_s3_i;
  assign far_s[0] = far_s0_i;
  assign far_s[1] = far_s1_i;
  assign far_s[2] = far_s2_i;
  assign far_s[3] = far_s3_i;

  dcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dcs_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .mic_s_i         (mic_s),
    .far_s_i         (far_s),
    .frame_present_i (frame_present_i),
    .last_frame_i    (last_frame_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .score_o         (score_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule
`default_nettype wire

>>> tb/tb_downmix_cosine_similarity.sv
// testbench for the downmix cosine similarity block: random frames checked against a predictor
`default_nettype none
module tb_downmix_cosine_similarity;
  timeunit 1ns;
  timeprecision 1ps;

  class corr_scoreboard;
    logic [2:0] mic_ch_reg;
    logic [2:0] far_ch_reg;
    logic signed [63:0] dot_sum;
    logic [63:0] mic_pwr;
    logic [63:0] far_pwr;
    bit seen_frame;
    logic signed [17:0] score_q[$];
    int errors;

    function new();
      mic_ch_reg = 3'd1;
      far_ch_reg = 3'd1;
      errors = 0;
      clear_sums();
    endfunction

    function void clear_sums();
      dot_sum = '0;
      mic_pwr = '0;
      far_pwr = '0;
      seen_frame = 0;
    endfunction

    function void set_reg(logic idx, logic [2:0] v);
      if (idx == dcs_pkg::CFG_MIC_CHANNELS) mic_ch_reg = v;
      else far_ch_reg = v;
    endfunction

    // channel count of 0 acts as 1, above the four fields saturates
    function int active_channels(logic [2:0] r);
      int n;
      n = r;
      if (n == 0) n = 1;
      if (n > 4) n = 4;
      return n;
    endfunction

    function logic signed [63:0] downmix(logic signed [23:0] s[4], logic [2:0] r);
      int n;
      logic signed [63:0] sum;
      logic signed [63:0] m;
      n = active_channels(r);
      sum = '0;
      for (int i = 0; i < n; i++) sum += 64'(s[i]);
      m = (sum * 64'((65536 + n / 2) / n) + 64'sd32768) >>> 16;
      if (m > 64'sd8388607) m = 64'sd8388607;
      if (m < -64'sd8388608) m = -64'sd8388608;
      return m;
    endfunction

    function logic signed [17:0] correlation();
      logic [63:0] mag;
      logic [199:0] prod;
      logic [199:0] dot_sq;
      logic [199:0] trial;
      longint lo;
      longint hi;
      longint mid;
      if (!seen_frame || mic_pwr == 0 || far_pwr == 0) return '0;
      mag = dot_sum[63] ? (~dot_sum + 64'd1) : dot_sum;
      prod = 200'(mic_pwr) * 200'(far_pwr);
      dot_sq = (200'(mag) * 200'(mag)) << 32;
      lo = 0;
      hi = 65536;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        trial = prod * 200'(mid * mid);
        if (trial <= dot_sq) lo = mid;
        else hi = mid - 1;
      end
      return dot_sum[63] ? -18'(lo) : 18'(lo);
    endfunction

    function void note_frame(logic signed [23:0] mic[4], logic signed [23:0] far[4],
                             logic present, logic last);
      logic signed [63:0] m;
      logic signed [63:0] f;
      logic signed [63:0] p;
      logic signed [64:0] t;
      logic [64:0] u;
      if (present) begin
        m = downmix(mic, mic_ch_reg);
        f = downmix(far, far_ch_reg);
        p = m * f;
        t = {dot_sum[63], dot_sum} + {p[63], p};
        if (t[64] != t[63]) dot_sum = t[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else dot_sum = t[63:0];
        u = {1'b0, mic_pwr} + 65'(m * m);
        mic_pwr = u[64] ? '1 : u[63:0];
        u = {1'b0, far_pwr} + 65'(f * f);
        far_pwr = u[64] ? '1 : u[63:0];
        seen_frame = 1;
      end
      if (last) begin
        score_q.push_back(correlation());
        clear_sums();
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check(logic signed [17:0] got);
      logic signed [17:0] want;
      if (score_q.size() == 0) begin
        report($sformatf("unexpected score %0d", got));
      end else begin
        want = score_q.pop_front();
        if (got !== want) report($sformatf("score %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic cfg_idx_i = 0;
  logic [2:0] cfg_data_i = '0;
  logic in_valid_i = 0;
  logic in_ready_o;
  logic signed [23:0] mic_s0_i = '0, mic_s1_i = '0, mic_s2_i = '0, mic_s3_i = '0;
  logic signed [23:0] far_s0_i = '0, far_s1_i = '0, far_s2_i = '0, far_s3_i = '0;
  logic frame_present_i = 0;
  logic last_frame_i = 0;
  logic out_valid_o;
  logic out_ready_i = 0;
  logic signed [17:0] score_o;

  corr_scoreboard sb = new();
  bit no_idle = 0;
  int hold_req = 0;
  logic signed [23:0] mic_v[4];
  logic signed [23:0] far_v[4];

  always #10 clk_i = ~clk_i;

  downmix_cosine_similarity DUT (.*);

  // receiver: random stalls, plus long hold-offs on request
  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      out_ready_i <= 0;
      hold_req <= hold_req - 1;
    end else begin
      out_ready_i <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 11);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check(score_o);
  end

  task cfg_write(logic idx, logic [2:0] v);
    @(negedge clk_i);
    cfg_we_i = 1;
    cfg_idx_i = idx;
    cfg_data_i = v;
    @(negedge clk_i);
    cfg_we_i = 0;
    sb.set_reg(idx, v);
  endtask

  task send_frame(logic present, logic last);
    @(negedge clk_i);
    in_valid_i = 1;
    {mic_s0_i, mic_s1_i, mic_s2_i, mic_s3_i} = {mic_v[0], mic_v[1], mic_v[2], mic_v[3]};
    {far_s0_i, far_s1_i, far_s2_i, far_s3_i} = {far_v[0], far_v[1], far_v[2], far_v[3]};
    frame_present_i = present;
    last_frame_i = last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_frame(mic_v, far_v, present, last);
    if (!no_idle && $urandom_range(0, 99) < 11) begin
      @(negedge clk_i);
      in_valid_i = 0;
      repeat ($urandom_range(0, 4)) @(negedge clk_i);
    end
  endtask

  // waits for all scores, then lets an in-flight frame settle
  task drain();
    @(negedge clk_i);
    in_valid_i = 0;
    while (sb.score_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task fill_all(logic signed [23:0] v);
    for (int i = 0; i < 4; i++) begin
      mic_v[i] = v;
      far_v[i] = v;
    end
  endtask

  task random_samples();
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 4; i++) begin
      mic_v[i] = 24'($urandom);
      if (mode < 2) far_v[i] = mic_v[i];
      else if (mode < 3) far_v[i] = -mic_v[i];
      else if (mode < 4) far_v[i] = 24'($urandom_range(0, 255)) - 24'sd128;
      else far_v[i] = 24'($urandom);
    end
  endtask

  // a buffer of frames ending in a last frame, sometimes broken by empty frames
  task random_buffer(int len);
    for (int k = 0; k < len; k++) begin
      random_samples();
      send_frame($urandom_range(0, 9) != 0, k == len - 1);
    end
  endtask

  initial begin
    logic [2:0] mic_set[7] = '{3'd1, 3'd4, 3'd0, 3'd2, 3'd7, 3'd3, 3'd5};
    logic [2:0] far_set[7] = '{3'd4, 3'd1, 3'd7, 3'd3, 3'd0, 3'd2, 3'd6};
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: reset channel counts, empty buffers, zero energy, extremes
    fill_all('0);
    send_frame(1'b0, 1'b1);
    send_frame(1'b1, 1'b1);
    fill_all(24'sh7FFFFF);
    send_frame(1'b1, 1'b0);
    send_frame(1'b0, 1'b1);
    fill_all(-24'sd8388608);
    send_frame(1'b1, 1'b1);
    mic_v = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF};
    far_v = '{-24'sd8388608, -24'sd8388608, -24'sd8388608, -24'sd8388608};
    send_frame(1'b1, 1'b0);
    send_frame(1'b1, 1'b1);
    far_v = '{24'sd0, 24'sd1, 24'sd0, 24'sd0};
    send_frame(1'b1, 1'b1);
    drain();
    cfg_write(dcs_pkg::CFG_MIC_CHANNELS, 3'd4);
    cfg_write(dcs_pkg::CFG_FAR_CHANNELS, 3'd4);
    mic_v = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF};
    far_v = '{24'sh7FFFFF, -24'sd8388608, 24'sd5, -24'sd3};
    send_frame(1'b1, 1'b0);
    mic_v = '{24'sd1, 24'sd1, 24'sd0, 24'sd0};
    send_frame(1'b1, 1'b1);
    mic_v = '{24'sd1, 24'sd0, 24'sd0, 24'sd0};
    far_v = mic_v;
    send_frame(1'b1, 1'b1);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      cfg_write(dcs_pkg::CFG_MIC_CHANNELS, mic_set[ph]);
      cfg_write(dcs_pkg::CFG_FAR_CHANNELS, far_set[ph]);
      no_idle = (ph == 3);
      for (int b = 0; b < 14; b++) begin
        if (ph == 1 && b == 2) hold_req = 400;
        random_buffer($urandom_range(1, 8));
        if (ph == 5 && b == 6) drain();
      end
      drain();
    end
    no_idle = 0;

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
